// ===== src/bbdh_pkg.sv =====
// shared types and constants for the button bank debounce and hold unit
// no dependencies
package bbdh_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_WATCH_A_BUTTON = 2'd0;
    localparam logic [1:0] CFG_WATCH_A_TICKS  = 2'd1;
    localparam logic [1:0] CFG_WATCH_B_BUTTON = 2'd2;
    localparam logic [1:0] CFG_WATCH_B_TICKS  = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int BTN_W      = 5;
    localparam int TICK_W     = 9;

    // register defaults after reset
    localparam logic [BTN_W-1:0]  WATCH_A_BUTTON_RST = 5'd0;
    localparam logic [TICK_W-1:0] WATCH_A_TICKS_RST  = 9'd50;
    localparam logic [BTN_W-1:0]  WATCH_B_BUTTON_RST = 5'd1;
    localparam logic [TICK_W-1:0] WATCH_B_TICKS_RST  = 9'd300;

    // event kinds
    localparam logic KIND_CHANGE = 1'b0;
    localparam logic KIND_HOLD   = 1'b1;

    // one event without its last-of-scan mark
    typedef struct packed {
        logic [BTN_W-1:0] button_index;
        logic             level;
        logic             event_kind;
    } event_t;

endpackage

// ===== src/bbdh_event_out.sv =====
// event holding stage and output register; marks the last beat of a scan
// depends on bbdh_pkg
module bbdh_event_out
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            evt_push,
    input  bbdh_pkg::event_t evt,
    input  logic            flush,
    output logic            evq_ready,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [4:0]      button_index,
    output logic            level,
    output logic            event_kind,
    output logic            last_event
);

    logic             pend_vld_reg;
    bbdh_pkg::event_t pend_reg;
    logic             out_vld_reg;
    bbdh_pkg::event_t out_evt_reg;
    logic             out_last_reg;
    logic             out_free;
    logic             move;

    // pending event leaves once the next one arrives or the scan ends
    assign out_free  = !out_vld_reg || !out_stall;
    assign move      = pend_vld_reg && out_free && (evt_push || flush);
    assign evq_ready = !pend_vld_reg || out_free;

    // pending control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (evt_push)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_vld_reg <= 1'b0;
            end
            if (move)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (evt_push)
        begin
            pend_reg <= evt;
        end
        if (move)
        begin
            out_evt_reg  <= pend_reg;
            out_last_reg <= flush;
        end
    end

    assign out_valid    = out_vld_reg;
    assign button_index = out_evt_reg.button_index;
    assign level        = out_evt_reg.level;
    assign event_kind   = out_evt_reg.event_kind;
    assign last_event   = out_last_reg;

endmodule

// ===== src/button_bank_debounce_hold_unit.sv =====
// A scan runs from accept until the unit is idle again, and a stalled output can hold it. Each
// beat waits in a holding stage until the next event of the scan or the scan end pushes it
// out; the last beat is pushed out at the scan end, after the hold checks. A new scan is
// accepted only in idle, and a scan reads the history memory once per button. Reset clears
// levels, history valid bits and hold counts, sets the watch enables and restores register
// defaults; no clearing pass, the block is ready at once.
// top level of the debouncer; history memory, sequencer and hold watches
// depends on bbdh_pkg and bbdh_event_out
module button_bank_debounce_hold_unit
#(
    parameter int BUTTON_COUNT   = 32,
    parameter int STABLE_SAMPLES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] raw_pins,
    input  logic        report_events,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [bbdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbdh_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  button_index,
    output logic        level,
    output logic        event_kind,
    output logic        last_event
);

    localparam int AW    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int CNT_W = $clog2(BUTTON_COUNT + 1);
    localparam int HW    = STABLE_SAMPLES;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_HOLD_A = 5'b00100,
        ST_HOLD_B = 5'b01000,
        ST_FLUSH  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [bbdh_pkg::BTN_W-1:0]  watch_a_button_reg;
    logic [bbdh_pkg::TICK_W-1:0] watch_a_ticks_reg;
    logic [bbdh_pkg::BTN_W-1:0]  watch_b_button_reg;
    logic [bbdh_pkg::TICK_W-1:0] watch_b_ticks_reg;

    logic [31:0]             pins_reg;
    logic                    report_reg;
    logic [BUTTON_COUNT-1:0] levels_reg;
    logic [BUTTON_COUNT-1:0] hist_vld_reg;
    logic [1:0]              watch_en_reg;
    logic [bbdh_pkg::TICK_W-1:0] cnt_a_reg;
    logic [bbdh_pkg::TICK_W-1:0] cnt_b_reg;

    logic [CNT_W-1:0] rd_cnt_reg;
    logic             p_vld_reg;
    logic [AW-1:0]    p_idx_reg;
    logic [HW-1:0]    rdata_reg;
    logic             rd_hvld_reg;

    logic [HW-1:0] hist_mem [BUTTON_COUNT];

    logic          in_accept;
    logic          evq_ready;
    logic          evt_push;
    bbdh_pkg::event_t evt;
    logic          flush;

    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          mem_re;
    logic          mem_we;
    logic [HW-1:0] hist_old;
    logic [HW-1:0] hist_new;
    logic          stable_hi;
    logic          stable_lo;
    logic          changed;
    logic          proc_evt;
    logic          proc_ok;
    logic          advance;
    logic          rd_more;

    logic [31:0]   lvl32;
    logic          lvl_a;
    logic          lvl_b;
    logic          en_a;
    logic          en_b;
    logic          held_a;
    logic          held_b;
    logic          fire_a;
    logic          fire_b;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_a_button_reg <= bbdh_pkg::WATCH_A_BUTTON_RST;
            watch_a_ticks_reg  <= bbdh_pkg::WATCH_A_TICKS_RST;
            watch_b_button_reg <= bbdh_pkg::WATCH_B_BUTTON_RST;
            watch_b_ticks_reg  <= bbdh_pkg::WATCH_B_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bbdh_pkg::CFG_WATCH_A_BUTTON: watch_a_button_reg <= cfg_data[4:0];
                bbdh_pkg::CFG_WATCH_A_TICKS:  watch_a_ticks_reg  <= cfg_data;
                bbdh_pkg::CFG_WATCH_B_BUTTON: watch_b_button_reg <= cfg_data[4:0];
                bbdh_pkg::CFG_WATCH_B_TICKS:  watch_b_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // debounce pipeline: read one entry while the previous one is updated
    assign rd_more   = (rd_cnt_reg < CNT_W'(BUTTON_COUNT));
    assign raddr     = rd_cnt_reg[AW-1:0];
    assign waddr     = p_idx_reg;
    assign hist_old  = rd_hvld_reg ? rdata_reg : '0;
    assign hist_new  = {hist_old[HW-2:0], ~pins_reg[p_idx_reg]};
    assign stable_hi = &hist_new;
    assign stable_lo = ~|hist_new;
    assign changed   = (stable_hi && !levels_reg[p_idx_reg])
                    || (stable_lo && levels_reg[p_idx_reg]);
    assign proc_evt  = p_vld_reg && changed && report_reg;
    assign proc_ok   = !proc_evt || evq_ready;
    assign advance   = !p_vld_reg || proc_ok;
    assign mem_re    = (state_reg == ST_SCAN) && advance && rd_more;
    assign mem_we    = p_vld_reg && proc_ok;

    // history memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[waddr] <= hist_new;
        end
        if (mem_re)
        begin
            rdata_reg <= hist_mem[raddr];
        end
    end

    // watch logic on the levels left by the debounce pass
    assign lvl32  = 32'(levels_reg);
    assign lvl_a  = lvl32[watch_a_button_reg];
    assign lvl_b  = lvl32[watch_b_button_reg];
    assign en_a   = watch_en_reg[0] || !lvl_a;
    assign en_b   = watch_en_reg[1] || !lvl_b;
    assign held_a = lvl_a && en_a;
    assign held_b = lvl_b && en_b;
    assign fire_a = held_a && (cnt_a_reg >= watch_a_ticks_reg);
    assign fire_b = held_b && (cnt_b_reg >= watch_b_ticks_reg);

    // event source select
    always_comb
    begin
        evt_push = 1'b0;
        evt      = '0;
        flush    = 1'b0;
        case (state_reg)
            ST_SCAN:
            begin
                evt_push         = proc_evt && evq_ready;
                evt.button_index = 5'(p_idx_reg);
                evt.level        = stable_hi;
                evt.event_kind   = bbdh_pkg::KIND_CHANGE;
            end
            ST_HOLD_A:
            begin
                evt_push         = fire_a && evq_ready;
                evt.button_index = watch_a_button_reg;
                evt.level        = 1'b1;
                evt.event_kind   = bbdh_pkg::KIND_HOLD;
            end
            ST_HOLD_B:
            begin
                evt_push         = fire_b && evq_ready;
                evt.button_index = watch_b_button_reg;
                evt.level        = 1'b1;
                evt.event_kind   = bbdh_pkg::KIND_HOLD;
            end
            ST_FLUSH:
            begin
                flush = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!rd_more && !p_vld_reg)
                begin
                    state_next = ST_HOLD_A;
                end
            end
            ST_HOLD_A:
            begin
                if (!fire_a || evq_ready)
                begin
                    state_next = ST_HOLD_B;
                end
            end
            ST_HOLD_B:
            begin
                if (!fire_b || evq_ready)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (evq_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            p_vld_reg    <= 1'b0;
            levels_reg   <= '0;
            hist_vld_reg <= '0;
            watch_en_reg <= 2'b11;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                rd_cnt_reg <= '0;
            end
            else if (mem_re)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (advance)
            begin
                p_vld_reg <= mem_re;
            end
            // history and level write-back
            if (mem_we)
            begin
                hist_vld_reg[waddr] <= 1'b1;
                if (stable_hi)
                begin
                    levels_reg[waddr] <= 1'b1;
                end
                else if (stable_lo)
                begin
                    levels_reg[waddr] <= 1'b0;
                end
            end
            // watch a
            if ((state_reg == ST_HOLD_A) && (!fire_a || evq_ready))
            begin
                if (fire_a)
                begin
                    watch_en_reg[0] <= 1'b0;
                    cnt_a_reg       <= '0;
                end
                else
                begin
                    watch_en_reg[0] <= en_a;
                    cnt_a_reg       <= held_a ? cnt_a_reg + 1'b1 : '0;
                end
            end
            // watch b
            if ((state_reg == ST_HOLD_B) && (!fire_b || evq_ready))
            begin
                if (fire_b)
                begin
                    watch_en_reg[1] <= 1'b0;
                    cnt_b_reg       <= '0;
                end
                else
                begin
                    watch_en_reg[1] <= en_b;
                    cnt_b_reg       <= held_b ? cnt_b_reg + 1'b1 : '0;
                end
            end
        end
    end

    // scan payload and read-side bookkeeping
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pins_reg   <= raw_pins;
            report_reg <= report_events;
        end
        if (mem_re)
        begin
            p_idx_reg   <= raddr;
            rd_hvld_reg <= hist_vld_reg[raddr];
        end
    end

    bbdh_event_out u_event_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt_push     (evt_push),
        .evt          (evt),
        .flush        (flush),
        .evq_ready    (evq_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .button_index (button_index),
        .level        (level),
        .event_kind   (event_kind),
        .last_event   (last_event)
    );

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_proc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> (state_reg == ST_SCAN))
        else $error("debounce stage busy outside a scan");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> ((state_reg == ST_SCAN) && (rd_cnt_reg == '0) && !p_vld_reg))
        else $error("accepted scan did not start at the first button");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (raddr != waddr))
        else $error("history read and write hit the same entry");

    a_push_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        evt_push |-> evq_ready)
        else $error("event pushed while output side full");
`endif

endmodule
